/* hdl/cpd_pkg.sv */
// Shared types, constants and helpers of the clap peak detector.
// No dependencies; imported by every module of the block.
package cpd_pkg;

    localparam int TIME_WIDTH      = 32;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int NOW_WIDTH       = 32;
    localparam int PEAK_WIDTH      = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLAP_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ECHO_COOLDOWN  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE       = 2'd2;

    localparam logic [CFG_WIDTH-1:0] CLAP_THRESHOLD_RESET = 16'd4096;
    localparam logic [CFG_WIDTH-1:0] ECHO_COOLDOWN_RESET  = 16'd500;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET       = 16'd800;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [PEAK_WIDTH-1:0] peak_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] clap_threshold;
        logic [CFG_WIDTH-1:0] echo_cooldown;
        logic [CFG_WIDTH-1:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           frame_end;
        logic [NOW_WIDTH-1:0]           now_ms;
        logic                           playback_active;
    } item_t;

    typedef struct packed {
        peak_t frame_peak;
        logic  clap_detected;
    } result_t;

    // |sample|; the most negative value maps to 32768, which still fits
    function automatic peak_t magnitude(input logic signed [SAMPLE_WIDTH-1:0] s);
        peak_t m;
        if (s[SAMPLE_WIDTH-1])
            m = PEAK_WIDTH'(~s + 1'b1);
        else
            m = PEAK_WIDTH'(s);
        return m;
    endfunction

endpackage

/* hdl/cpd_cfg_regs.sv */
// Configuration register file of the clap peak detector.
// Depends on cpd_pkg for the register indexes, reset values and cfg_t.
module cpd_cfg_regs
    import cpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLAP_THRESHOLD: cfg_next.clap_threshold = cfg_data;
                REG_ECHO_COOLDOWN:  cfg_next.echo_cooldown  = cfg_data;
                REG_DEBOUNCE:       cfg_next.debounce_ms    = cfg_data;
                default:            cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clap_threshold <= CLAP_THRESHOLD_RESET;
            cfg_reg.echo_cooldown  <= ECHO_COOLDOWN_RESET;
            cfg_reg.debounce_ms    <= DEBOUNCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/cpd_detect.sv */
// Peak tracker and clap decision with echo window and holdoff state.
// Depends on cpd_pkg; result is combinational from the registered item.
module cpd_detect
    import cpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    peak_t peak_reg;
    peak_t peak_next;
    logic  was_active_reg;
    logic  was_active_next;
    time_t end_time_reg;
    time_t end_time_next;
    time_t last_clap_reg;
    time_t last_clap_next;

    peak_t mag;
    peak_t peak;
    time_t now;
    logic  echo;
    logic  clap;

    always_comb
    begin
        mag  = magnitude(item.sample);
        peak = (mag > peak_reg) ? mag : peak_reg;
        now  = TIME_WIDTH'(item.now_ms);

        // Playback just stopped: the cooldown starts now
        end_time_next = end_time_reg;
        if (was_active_reg && !item.playback_active)
            end_time_next = now;

        echo = item.playback_active ||
               ((now - end_time_next) < TIME_WIDTH'(cfg.echo_cooldown));
        clap = !echo && (peak >= cfg.clap_threshold) &&
               ((now - last_clap_reg) > TIME_WIDTH'(cfg.debounce_ms));

        last_clap_next  = clap ? now : last_clap_reg;
        was_active_next = item.playback_active;
        peak_next       = item.frame_end ? '0 : peak;

        result.frame_peak    = peak;
        result.clap_detected = clap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            was_active_reg <= 1'b0;
            end_time_reg   <= '0;
            last_clap_reg  <= '0;
        end
        else if (step)
        begin
            peak_reg <= peak_next;
            if (item.frame_end)
            begin
                was_active_reg <= was_active_next;
                end_time_reg   <= end_time_next;
                last_clap_reg  <= last_clap_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_peak_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.frame_end |=> peak_reg == '0)
        else $error("running peak not cleared after frame end");

    a_timing_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && item.frame_end) |=> $stable(end_time_reg) && $stable(last_clap_reg)
            && $stable(was_active_reg))
        else $error("time state changed outside a frame end");

    a_clap_stamps: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.frame_end && result.clap_detected |=> last_clap_reg == $past(now))
        else $error("clap did not record its timestamp");

    a_peak_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.frame_end |=> peak_reg >= $past(peak_reg))
        else $error("running peak decreased within a frame");
`endif

endmodule

/* hdl/clap_peak_detector.sv */
// Top level of the clap peak detector: stream ports, input and result registers.
// Depends on cpd_pkg, cpd_cfg_regs and cpd_detect.
//
// Samples arrive as stream transfers on the s_ group: s_tdata carries the
// signed sample and the millisecond timestamp, s_tlast marks the last sample
// of a frame, s_tuser the playback-active flag. Timestamp and flag count only
// on the s_tlast transfer. Each frame end yields one result transfer on the
// m_ group: m_tdata holds the frame peak |sample|, m_tuser is 1 for a clap.
// Throughput: one sample per cycle, unless a frame end waits for room in the
// result register; the input register feeds one level of compare/subtract
// logic into the result register. Path: a frame-end transfer loads the input
// register, then its result loads the result register, which drives m_tvalid.
// Stall: while a result waits with m_tready low, inner samples still advance;
// a frame-end sample holds in the input register with s_tready low until the
// result register frees.
// Reset (rst_n low): clear the running peak, the playback and clap timestamps
// and both valid flags; registers return to threshold 4096, cooldown 500 ms,
// debounce 800 ms. Write registers through cfg_ only while nothing is in flight.
module clap_peak_detector
    import cpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    // sample stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // [15:0] sample, [47:16] now_ms
    input  logic                       s_tlast,   // frame_end
    input  logic [0:0]                 s_tuser,   // [0] playback_active
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // [15:0] frame_peak
    output logic [0:0]                 m_tuser    // [0] clap_detected
);

    cfg_t    cfg;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result;

    logic s_xfer;
    logic out_free;
    logic step;
    logic emit;

    cpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpd_detect u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Result register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // Advance the held sample; only a frame end needs room for its result
    assign step     = in_valid_reg && (!in_item_reg.frame_end || out_free);
    assign emit     = step && in_item_reg.frame_end;
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next.sample          = s_tdata[15:0];
        in_item_next.frame_end       = s_tlast;
        in_item_next.now_ms          = s_tdata[47:16];
        in_item_next.playback_active = s_tuser[0];

        in_valid_next  = s_xfer || (in_valid_reg && !step);
        out_valid_next = emit || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_item_reg <= in_item_next;
        if (emit)
            out_reg <= result;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.frame_peak;
    assign m_tuser[0] = out_reg.clap_detected;

endmodule

/* dv/tb_clap_peak_detector.sv */
// Self-checking testbench for the clap peak detector: frame peak and clap decision.
// Depends on cpd_pkg and clap_peak_detector; holds its own frame predictor and result scoreboard.
`timescale 1ns / 100ps

module tb_clap_peak_detector;
    import cpd_pkg::*;

    localparam int HOLD_CYCLES    = 300;  // long receiver hold-off, fills the block
    localparam int RANDOM_ITEMS   = 400;
    localparam int PHASE_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 4;    // settle time after the last result comes back

    // Scoreboard: predicts the result of each frame-end transfer and checks
    // returned results against the oldest prediction.
    class clap_scoreboard;
        cfg_t        regs;
        int          frame_max;
        logic        was_playing;
        time_t       playback_stop_ms;
        time_t       last_clap_stamp;
        result_t     frame_results[$];
        int unsigned mismatches;

        function new();
            regs.clap_threshold = CLAP_THRESHOLD_RESET;
            regs.echo_cooldown  = ECHO_COOLDOWN_RESET;
            regs.debounce_ms    = DEBOUNCE_RESET;
            frame_max           = 0;
            was_playing         = 1'b0;
            playback_stop_ms    = '0;
            last_clap_stamp     = '0;
            mismatches          = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
            case (idx)
                REG_CLAP_THRESHOLD: regs.clap_threshold = val;
                REG_ECHO_COOLDOWN:  regs.echo_cooldown  = val;
                REG_DEBOUNCE:       regs.debounce_ms    = val;
                default: ;
            endcase
        endfunction

        // Fold one accepted sample into the frame; on frame end queue the result.
        function void take_sample(item_t it);
            int      s;
            int      mag;
            int      pk;
            time_t   now;
            time_t   since_stop;
            time_t   since_clap;
            logic    echo;
            logic    clap;
            result_t r;
            s   = $signed(it.sample);
            mag = (s < 0) ? -s : s;
            pk  = (mag > frame_max) ? mag : frame_max;
            if (!it.frame_end)
            begin
                frame_max = pk;
                return;
            end
            now = it.now_ms;
            // falling edge of playback starts the echo cooldown
            if (was_playing && !it.playback_active)
                playback_stop_ms = now;
            was_playing = it.playback_active;
            since_stop  = now - playback_stop_ms;
            since_clap  = now - last_clap_stamp;
            echo = it.playback_active || (since_stop < time_t'(regs.echo_cooldown));
            clap = !echo && (pk >= int'(regs.clap_threshold))
                   && (since_clap > time_t'(regs.debounce_ms));
            if (clap)
                last_clap_stamp = now;
            r.frame_peak    = peak_t'(pk);
            r.clap_detected = clap;
            frame_results.push_back(r);
            frame_max = 0;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (frame_results.size() == 0)
            begin
                $display("%0t: result with no frame pending, actual peak=%0d clap=%0b",
                         $time, got.frame_peak, got.clap_detected);
                mismatches++;
                return;
            end
            want = frame_results.pop_front();
            if (got.frame_peak !== want.frame_peak || got.clap_detected !== want.clap_detected)
            begin
                $display("%0t: result mismatch, expected peak=%0d clap=%0b, actual peak=%0d clap=%0b",
                         $time, want.frame_peak, want.clap_detected,
                         got.frame_peak, got.clap_detected);
                mismatches++;
            end
        endfunction

        function int pending();
            return frame_results.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [47:0]                s_tdata;   // [15:0] sample, [47:16] now_ms
    logic                       s_tlast;   // frame_end
    logic [0:0]                 s_tuser;   // [0] playback_active
    logic                       m_tvalid;
    logic                       m_tready;
    logic [15:0]                m_tdata;   // [15:0] frame_peak
    logic [0:0]                 m_tuser;   // [0] clap_detected

    clap_scoreboard sb = new();

    logic        quiet;        // no idling on either side while set
    logic        hold_req;     // ask the receiver for one long hold-off
    int unsigned items_sent;
    time_t       stream_ms;    // timestamp of the well-formed frame stream
    logic        playing;      // current playback state of that stream
    result_t     seen_result;

    clap_peak_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Idle length: mostly none, often short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix the extremes with plain random sample values.
    function automatic logic [15:0] rand_sample();
        logic [15:0] mag;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return 16'($urandom);
            default:
            begin
                mag = 16'($urandom_range(0, 8000));
                return ($urandom_range(0, 1) != 0) ? -mag : mag;
            end
        endcase
    endfunction

    // Offer one sample, wait for its transfer, then note it in the scoreboard.
    // Leave tvalid high so a following item goes out back to back.
    task automatic send_item(input logic [15:0] smp, input logic last,
                             input logic [31:0] now, input logic play);
        int    g;
        item_t it;
        g = quiet ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, smp};
        s_tlast  <= last;
        s_tuser  <= play;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        it.sample          = smp;
        it.frame_end       = last;
        it.now_ms          = now;
        it.playback_active = play;
        sb.take_sample(it);
        items_sent++;
    endtask

    task automatic end_frame(input logic [15:0] smp, input logic [31:0] now, input logic play);
        send_item(smp, 1'b1, now, play);
    endtask

    // One well-formed frame: a few samples, then the frame end with a timestamp that
    // mostly advances and the playback flag. Timestamp and flag of inner samples are noise.
    task automatic send_frame();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int i = 1; i < len; i++)
            send_item(rand_sample(), 1'b0, $urandom, 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3, 4: stream_ms = stream_ms + $urandom_range(1, 400);
            5, 6, 7: stream_ms = stream_ms + $urandom_range(400, 3000);
            8: stream_ms = stream_ms + $urandom_range(3000, 100000);
            default: stream_ms = $urandom;
        endcase
        if ($urandom_range(0, 9) == 0)
            playing = ~playing;
        end_frame(rand_sample(), stream_ms, playing);
    endtask

    task automatic cfg_transfer(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [CFG_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Write all three registers back to back; drop valid once at the end.
    task automatic load_config(input logic [CFG_WIDTH-1:0] thr,
                               input logic [CFG_WIDTH-1:0] cool,
                               input logic [CFG_WIDTH-1:0] deb);
        cfg_transfer(REG_CLAP_THRESHOLD, thr);
        cfg_transfer(REG_ECHO_COOLDOWN, cool);
        cfg_transfer(REG_DEBOUNCE, deb);
        cfg_valid <= 1'b0;
    endtask

    // Stop the sample stream until every frame result is back, then let the
    // pipeline settle so a trailing inner sample is absorbed too.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Check every result transfer as it completes.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.frame_peak    = m_tdata;
            seen_result.clap_detected = m_tuser[0];
            sb.check_result(seen_result);
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request so the
    // block backs up and drops s_tready while samples keep coming.
    initial
    begin
        int g;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                g = quiet ? 0 : gap_len();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Main sequence: reset, directed frames, then random phases with new settings.
    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        int unsigned directed_items;
        rst_n      = 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_CLAP_THRESHOLD;
        cfg_data   <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        s_tuser    <= 1'b0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        stream_ms  = 32'd100000;
        playing    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: threshold 4096, cooldown 500, debounce 800.
        // Small timestamp right after reset sits in the cooldown window.
        end_frame(16'h0000, 32'd0, 1'b0);
        // Most negative sample gives peak 32768; inner timestamp/flag are ignored.
        send_item(16'h8000, 1'b0, 32'hFFFF_FFFF, 1'b1);
        end_frame(16'd100, 32'd10000, 1'b0);
        // Holdoff: 500 and exactly 800 ms later are rejected, 801 passes.
        end_frame(16'h7FFF, 32'd10500, 1'b0);
        end_frame(16'd5000, 32'd10800, 1'b0);
        end_frame(-16'd5000, 32'd10801, 1'b0);
        // Playback, its end, cooldown boundary at 499 and 500 ms.
        end_frame(16'd20000, 32'd12000, 1'b1);
        end_frame(16'd20000, 32'd12100, 1'b0);
        end_frame(16'd20000, 32'd12599, 1'b0);
        end_frame(16'd20000, 32'd12600, 1'b0);
        // Threshold boundary.
        end_frame(16'd4096, 32'd14000, 1'b0);
        end_frame(16'd4095, 32'd16000, 1'b0);
        end_frame(-16'd4096, 32'd18000, 1'b0);
        // Timestamp wrap: the holdoff is measured across the wrap.
        end_frame(16'd30000, 32'hFFFF_FF00, 1'b0);
        end_frame(16'd30000, 32'h0000_0200, 1'b0);
        end_frame(16'd30000, 32'h0000_0221, 1'b0);

        // Zero threshold, cooldown and debounce: any frame at a new time without playback is a clap.
        drain_results();
        load_config(16'd0, 16'd0, 16'd0);
        end_frame(16'h0000, 32'h0000_0300, 1'b0);
        end_frame(16'h0000, 32'h0000_0300, 1'b0);
        end_frame(16'h0000, 32'h0000_0301, 1'b1);
        end_frame(16'h0000, 32'h0000_0301, 1'b0);
        send_item(16'h7FFF, 1'b0, 32'd0, 1'b0);
        end_frame(16'h0001, 32'h0000_0302, 1'b0);
        directed_items = items_sent;

        // Random phases. Each one drains, loads new settings, and runs mostly
        // well-formed frames with some noise items mixed in.
        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            drain_results();
            case (phase)
                0: load_config(16'd32769, 16'd65535, 16'd65535);
                1: load_config(16'd65535, 16'd0, 16'd0);
                2: load_config(16'd32768, 16'd100, 16'd100);
                3: load_config(16'd0, 16'd65535, 16'd0);
                4: load_config(CLAP_THRESHOLD_RESET, ECHO_COOLDOWN_RESET, DEBOUNCE_RESET);
                default:
                    load_config(16'($urandom_range(0, 12000)), 16'($urandom_range(0, 3000)),
                                16'($urandom_range(0, 3000)));
            endcase
            quiet = (phase % 4 == 1);
            if (phase == 2)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_frame();
                else
                    send_item(16'($urandom), 1'($urandom_range(0, 1)), $urandom,
                              1'($urandom_range(0, 1)));
            end
            phase++;
        end

        // Wait out the last results, then a little longer for strays.
        quiet = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a correct run ends far earlier.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
